[design/apn_pkg.sv]
`timescale 1ns / 1ps
package apn_pkg;

    localparam int APN_BUFFER_DEPTH = 4096;

    localparam int SAMPLE_W  = 16;
    localparam int INDEX_W   = 12;
    localparam int MAG_W     = 16;
    localparam int QUOT_W    = 15;
    localparam int PROD_W    = QUOT_W + MAG_W - 1;
    localparam int DIV_CNT_W = $clog2(QUOT_W);

    localparam logic [QUOT_W-1:0] FULL_SCALE = QUOT_W'(32767);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_READ  = 1'b1;
    localparam logic FORMAT_S16 = 1'b0;
    localparam logic FORMAT_U8  = 1'b1;

    typedef struct packed {
        logic                kind;
        logic                start_new;
        logic [SAMPLE_W-1:0] raw_sample;
        logic [INDEX_W-1:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] scaled_sample;
        logic                       in_range;
    } t_out_item;

endpackage

[design/apn_store.sv]
`timescale 1ns / 1ps
module apn_store
    import apn_pkg::*;
#(
    parameter int DEPTH = APN_BUFFER_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]    i_wr_addr,
    input  logic [SAMPLE_W-1:0]         i_wr_data,
    input  logic                        i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]    i_rd_addr,
    output logic [SAMPLE_W-1:0]         o_rd_data
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/apn_div.sv]
`timescale 1ns / 1ps
module apn_div
    import apn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [MAG_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0]     r_rem;
    logic [QUOT_W-1:0]    r_shift;
    logic [MAG_W-1:0]     r_divisor;

    logic [MAG_W:0]       trial;
    logic                 take;
    logic [MAG_W:0]       diff;

    // restoring step, one quotient bit per cycle
    assign trial = {r_rem, r_shift[QUOT_W-1]};
    assign take  = (trial >= {1'b0, r_divisor});
    assign diff  = trial - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= '0;
                r_rem     <= MAG_W'(i_dividend[PROD_W-1:QUOT_W]);
                r_shift   <= i_dividend[QUOT_W-1:0];
                r_divisor <= i_divisor;
            end else if (r_busy) begin
                r_rem   <= take ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                r_shift <= {r_shift[QUOT_W-2:0], take};
                r_cnt   <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_shift;

endmodule

[design/audio_peak_normalizer_unit.sv]
// Audio peak normalizer. Load transfers (kind 0) write one sample into the buffer, converted
// from signed 16-bit or from unsigned 8-bit minus 128 as the sample_format register says, and
// track the peak magnitude; the block stays idle on a load and is ready again next cycle.
// Read transfers (kind 1) return trunc(32767 * s / peak) for the sample at read_index, zero for
// a silent buffer, and zero with in_range low past the loaded count. A read holds off the next
// input transfer while it passes through the transfer, a buffer read, a multiply, a divider
// start, the restoring divider (one quotient bit per cycle), a state that sees the divider
// finish and the write into the output register, which waits until the previous result in
// the output register is taken. A read past the count or of a silent buffer skips the divider.
// Loads beyond the buffer depth are dropped until a load with start_new begins a new buffer.
`timescale 1ns / 1ps
module audio_peak_normalizer_unit
    import apn_pkg::*;
#(
    parameter int BUFFER_DEPTH = APN_BUFFER_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_DIVLD,
        S_DIV,
        S_DONE
    } t_state;

    t_state              r_state;
    logic                r_format;
    logic [CW-1:0]       r_count;
    logic [MAG_W-1:0]    r_peak;
    logic [INDEX_W-1:0]  r_read_index;
    logic                r_in_range;
    logic                r_zero;
    logic                r_neg;
    logic [PROD_W-1:0]   r_prod;
    logic                r_out_valid;
    t_out_item           r_out_data;

    logic                in_xfer;
    logic                load_xfer;
    logic                load_room;
    logic                div_start;
    logic                div_done;
    logic [QUOT_W-1:0]   div_quot;
    logic signed [7:0]   byte_val;
    logic [SAMPLE_W-1:0] load_val;
    logic [MAG_W-1:0]    load_mag;
    logic [CW-1:0]       base_count;
    logic [MAG_W-1:0]    base_peak;
    logic [AW-1:0]       wr_addr;
    logic [XW-1:0]       idx_ext;
    logic [SAMPLE_W-1:0] rd_data;
    logic [MAG_W-1:0]    rd_mag;
    logic [PROD_W-1:0]   prod_full;
    logic [QUOT_W-1:0]   q_final;
    logic                out_free;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign load_xfer = in_xfer && (i_in_data.kind == KIND_LOAD);

    // sample conversion
    assign byte_val = {~i_in_data.raw_sample[7], i_in_data.raw_sample[6:0]};
    assign load_val = (r_format == FORMAT_U8) ? SAMPLE_W'(byte_val) : i_in_data.raw_sample;
    assign load_mag = load_val[SAMPLE_W-1] ? (~load_val + 1'b1) : load_val;

    assign base_count = i_in_data.start_new ? '0 : r_count;
    assign base_peak  = i_in_data.start_new ? '0 : r_peak;
    assign load_room  = (base_count < CW'(BUFFER_DEPTH));
    assign wr_addr    = base_count[AW-1:0];

    assign idx_ext = XW'(r_read_index);

    assign rd_mag    = rd_data[SAMPLE_W-1] ? (~rd_data + 1'b1) : rd_data;
    assign prod_full = PROD_W'(FULL_SCALE) * PROD_W'(rd_mag);

    assign div_start = (r_state == S_DIVLD);
    assign q_final   = r_zero ? '0 : div_quot;
    assign out_free  = !r_out_valid || i_out_ready;

    apn_store #(
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (load_xfer && load_room),
        .i_wr_addr (wr_addr),
        .i_wr_data (load_val),
        .i_rd_en   (r_state == S_RD),
        .i_rd_addr (idx_ext[AW-1:0]),
        .o_rd_data (rd_data)
    );

    apn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_peak),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_format    <= FORMAT_S16;
            r_count     <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_format <= i_cfg_wr_data;
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_read_index <= i_in_data.read_index;
                        if (i_in_data.kind == KIND_LOAD) begin
                            if (load_room) begin
                                r_count <= base_count + 1'b1;
                                r_peak  <= (load_mag > base_peak) ? load_mag : base_peak;
                            end else begin
                                r_count <= base_count;
                                r_peak  <= base_peak;
                            end
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_in_range <= (idx_ext < XW'(r_count));
                    r_state    <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= prod_full;
                    r_neg  <= rd_data[SAMPLE_W-1];
                    r_zero <= !r_in_range || (r_peak == '0);
                    if (!r_in_range || (r_peak == '0)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIVLD;
                    end
                end
                S_DIVLD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid              <= 1'b1;
                        r_out_data.in_range      <= r_in_range;
                        r_out_data.scaled_sample <= r_neg ? -$signed(SAMPLE_W'(q_final))
                                                          : $signed(SAMPLE_W'(q_final));
                        r_state                  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[design/apn_checker.sv]
`timescale 1ns / 1ps
module apn_checker
    import apn_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.in_range |-> o_out_data.scaled_sample == '0)
        else $error("out of range read gave nonzero sample");

    a_no_min_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.scaled_sample != 16'sh8000)
        else $error("scaled sample beyond full scale");

    // a read occupies the input side while the divider runs
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.kind == KIND_READ |=> !o_in_ready)
        else $error("input ready right after a read transfer");

    // a load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.kind == KIND_LOAD && !o_out_valid
        |=> !o_out_valid)
        else $error("result appeared after a load");

endmodule

bind audio_peak_normalizer_unit apn_checker u_apn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_in_data     (i_in_data),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_data    (o_out_data)
);

[dv/audio_peak_normalizer_unit_tb.sv]
`timescale 1ns / 1ps
module audio_peak_normalizer_unit_tb;
    import apn_pkg::*;

    localparam int TB_DEPTH     = 128;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE_WAIT  = 40;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 200;
    localparam int MAX_PRINTS   = 50;

    typedef enum logic {ROW_XFER, ROW_FORMAT} t_row_op;

    typedef struct packed {
        t_row_op            op;
        logic               fmt;
        logic               kind;
        logic               start_new;
        logic [15:0]        raw;
        logic [11:0]        idx;
        logic               typed;
        logic signed [15:0] exp_scaled;
        logic               exp_in_range;
    } t_stim_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_wr_en;
    logic      i_cfg_wr_data;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    // normalizer state as the block should hold it
    logic signed [SAMPLE_W-1:0] buf_store [TB_DEPTH];
    int   buf_count;
    int   buf_peak;
    logic fmt_reg;

    t_out_item expected_scaled_q [$];
    int  mismatch_count = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    bit  tx_burst;
    bit  rx_burst;
    int  rx_gap_left = 0;
    int  hold_left = 0;
    bit  hold_used = 1'b0;

    t_stim_row dir_tab [0:28] = '{
        '{ROW_FORMAT, FORMAT_S16, KIND_LOAD, 1'b0, 16'h0000, 12'h000, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_READ, 1'b0, 16'hFFFF, 12'h000, 1'b1, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_LOAD, 1'b1, 16'h0000, 12'hFFF, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_READ, 1'b0, 16'h0000, 12'h000, 1'b1, 16'sd0, 1'b1},
        '{ROW_XFER,   FORMAT_S16, KIND_READ, 1'b1, 16'h0000, 12'hFFF, 1'b1, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_LOAD, 1'b0, 16'h8000, 12'h000, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_LOAD, 1'b0, 16'h7FFF, 12'h000, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_LOAD, 1'b0, 16'h0001, 12'h000, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_LOAD, 1'b0, 16'hFFFF, 12'h000, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_READ, 1'b0, 16'h0000, 12'h001, 1'b1, -16'sd32767, 1'b1},
        '{ROW_XFER,   FORMAT_S16, KIND_READ, 1'b0, 16'h0000, 12'h002, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_READ, 1'b0, 16'h0000, 12'h003, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_READ, 1'b0, 16'h0000, 12'h004, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_READ, 1'b0, 16'h0000, 12'h005, 1'b1, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_LOAD, 1'b1, 16'h7FFF, 12'h000, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_READ, 1'b0, 16'h0000, 12'h000, 1'b1, 16'sd32767, 1'b1},
        '{ROW_XFER,   FORMAT_S16, KIND_LOAD, 1'b0, 16'hC000, 12'h000, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_READ, 1'b0, 16'h0000, 12'h001, 1'b0, 16'sd0, 1'b0},
        '{ROW_FORMAT, FORMAT_U8,  KIND_LOAD, 1'b0, 16'h0000, 12'h000, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_U8,  KIND_LOAD, 1'b1, 16'hAB00, 12'h000, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_U8,  KIND_LOAD, 1'b0, 16'h00FF, 12'h000, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_U8,  KIND_LOAD, 1'b0, 16'hFF80, 12'h000, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_U8,  KIND_READ, 1'b0, 16'h0000, 12'h000, 1'b1, -16'sd32767, 1'b1},
        '{ROW_XFER,   FORMAT_U8,  KIND_READ, 1'b0, 16'h0000, 12'h001, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_U8,  KIND_READ, 1'b0, 16'h0000, 12'h002, 1'b1, 16'sd0, 1'b1},
        '{ROW_FORMAT, FORMAT_S16, KIND_LOAD, 1'b0, 16'h0000, 12'h000, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_LOAD, 1'b0, 16'h1234, 12'h000, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_READ, 1'b0, 16'h0000, 12'h003, 1'b0, 16'sd0, 1'b0},
        '{ROW_XFER,   FORMAT_S16, KIND_READ, 1'b0, 16'h0000, 12'h000, 1'b0, 16'sd0, 1'b0}
    };

    audio_peak_normalizer_unit #(
        .BUFFER_DEPTH (TB_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS) begin
            $display("%0t mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic normalize_predict(input t_in_item it, output bit has_res,
                                     output t_out_item res);
        int     s;
        int     mag;
        longint q;
        has_res = 1'b0;
        res     = '0;
        if (it.kind == KIND_LOAD) begin
            if (fmt_reg == FORMAT_U8) begin
                s = int'(it.raw_sample[7:0]) - 128;
            end else begin
                s = int'($signed(it.raw_sample));
            end
            mag = (s < 0) ? -s : s;
            if (it.start_new) begin
                buf_count = 0;
                buf_peak  = 0;
            end
            if (buf_count < TB_DEPTH) begin
                buf_store[buf_count] = SAMPLE_W'(s);
                buf_count++;
                if (mag > buf_peak) begin
                    buf_peak = mag;
                end
            end
        end else begin
            has_res = 1'b1;
            if (int'(it.read_index) < buf_count) begin
                s   = int'(buf_store[it.read_index]);
                mag = (s < 0) ? -s : s;
                q   = 0;
                if (buf_peak != 0) begin
                    q = (longint'(FULL_SCALE) * mag) / buf_peak;
                    if (q > longint'(FULL_SCALE)) begin
                        q = longint'(FULL_SCALE);
                    end
                end
                if (s < 0) begin
                    q = -q;
                end
                res.scaled_sample = SAMPLE_W'(q);
                res.in_range      = 1'b1;
            end
        end
    endtask

    function automatic int unsigned pick_gap(input bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 16);
        end
        return $urandom_range(17, 80);
    endfunction

    // w == 0 gives silence, otherwise magnitudes up to 2**(w-1), with occasional full-scale extremes
    function automatic logic [15:0] make_sample(input int unsigned w);
        int lim;
        int v;
        if (w == 0) begin
            v = 0;
        end else begin
            case ($urandom_range(0, 24))
                0: return (fmt_reg == FORMAT_U8) ? {8'($urandom), 8'h00} : 16'h8000;
                1: return (fmt_reg == FORMAT_U8) ? {8'($urandom), 8'hFF} : 16'h7FFF;
                default: ;
            endcase
            lim = 1 << (w - 1);
            v   = int'($urandom_range(0, 2 * lim - 1)) - lim;
        end
        if (fmt_reg == FORMAT_U8) begin
            return {8'($urandom), 8'(v + 128)};
        end
        return 16'(v);
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        bit        has_res;
        t_out_item res;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        normalize_predict(it, has_res, res);
        if (has_res) begin
            expected_scaled_q.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic idle_tx(input int unsigned gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_scaled_q.size() != 0) begin
            @(posedge i_clk);
        end
        // loads leave no result, so give the last one time to retire
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_format(input logic f);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= f;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        fmt_reg = f;
    endtask

    // result side: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_used && results_seen >= HOLD_AFTER) begin
            hold_used = 1'b1;
            hold_left = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            rx_gap_left = pick_gap(rx_burst);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_scaled_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer scaled=%0d in_range=%0b",
                                          o_out_data.scaled_sample, o_out_data.in_range));
            end else begin
                exp_item = expected_scaled_q.pop_front();
                if (o_out_data.scaled_sample !== exp_item.scaled_sample) begin
                    report_mismatch($sformatf("scaled_sample got %0d exp %0d",
                                              o_out_data.scaled_sample,
                                              exp_item.scaled_sample));
                end
                if (o_out_data.in_range !== exp_item.in_range) begin
                    report_mismatch($sformatf("in_range got %0b exp %0b",
                                              o_out_data.in_range, exp_item.in_range));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("audio_peak_normalizer_unit test failed");
            $finish;
        end
    end

    initial begin
        t_in_item    it;
        t_out_item   tr;
        int unsigned w;
        int unsigned nload;
        int unsigned nread;
        int unsigned nseq;
        int          items_issued;
        int          phase_no;
        bit          fresh;
        logic        fmt;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        buf_count     = 0;
        buf_peak      = 0;
        fmt_reg       = FORMAT_S16;
        tx_burst      = 1'b0;
        rx_burst      = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (dir_tab[i]) begin
            if (dir_tab[i].op == ROW_FORMAT) begin
                set_format(dir_tab[i].fmt);
            end else begin
                it.kind           = dir_tab[i].kind;
                it.start_new      = dir_tab[i].start_new;
                it.raw_sample     = dir_tab[i].raw;
                it.read_index     = dir_tab[i].idx;
                tr.scaled_sample  = dir_tab[i].exp_scaled;
                tr.in_range       = dir_tab[i].exp_in_range;
                send_item(it, dir_tab[i].typed, tr);
                idle_tx(pick_gap(tx_burst));
            end
        end

        // fill the whole buffer, overflow it, then read the top end
        set_format(FORMAT_S16);
        tx_burst = 1'b1;
        for (int k = 0; k < TB_DEPTH + 3; k++) begin
            it.kind       = KIND_LOAD;
            it.start_new  = (k == 0);
            it.raw_sample = 16'($urandom);
            it.read_index = 12'($urandom);
            send_item(it, 1'b0, '0);
        end
        tx_burst = 1'b0;
        for (int k = 0; k < 12; k++) begin
            it.kind       = KIND_READ;
            it.start_new  = 1'($urandom);
            it.raw_sample = 16'($urandom);
            it.read_index = (k == 0) ? 12'(TB_DEPTH - 1) : (k == 1) ? 12'h000 : 12'($urandom);
            send_item(it, 1'b0, '0);
            idle_tx(pick_gap(tx_burst));
        end
        it.kind       = KIND_LOAD;
        it.start_new  = 1'b1;
        it.raw_sample = 16'($urandom);
        send_item(it, 1'b0, '0);
        for (int k = 0; k < 2; k++) begin
            it.kind       = KIND_READ;
            it.read_index = 12'(1 - k);
            send_item(it, 1'b0, '0);
        end

        // random buffers, each phase under one sample format
        items_issued = 0;
        phase_no     = 0;
        while (items_issued < RANDOM_ITEMS) begin
            fmt = (phase_no == 0) ? FORMAT_U8 :
                  (phase_no == 1) ? FORMAT_S16 : logic'($urandom_range(0, 1));
            set_format(fmt);
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst = ($urandom_range(0, 4) == 0);
            nseq = $urandom_range(1, 3);
            for (int sq = 0; sq < nseq; sq++) begin
                fresh = ($urandom_range(0, 4) != 0);
                w     = (fmt_reg == FORMAT_U8) ? $urandom_range(0, 8) : $urandom_range(0, 16);
                nload = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 200)
                                                    : $urandom_range(1, 32);
                for (int k = 0; k < nload; k++) begin
                    it.kind       = KIND_LOAD;
                    it.start_new  = (k == 0) ? fresh : ($urandom_range(0, 49) == 0);
                    it.raw_sample = make_sample(w);
                    it.read_index = 12'($urandom);
                    send_item(it, 1'b0, '0);
                    items_issued++;
                    idle_tx(pick_gap(tx_burst));
                end
                nread = $urandom_range(1, (nload > 20) ? 24 : nload + 4);
                for (int k = 0; k < nread; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        it.kind       = KIND_LOAD;
                        it.start_new  = ($urandom_range(0, 3) == 0);
                        it.raw_sample = 16'($urandom);
                    end else begin
                        it.kind       = KIND_READ;
                        it.start_new  = 1'($urandom);
                        it.raw_sample = 16'($urandom);
                    end
                    if (buf_count > 0 && $urandom_range(0, 3) != 0) begin
                        it.read_index = 12'($urandom_range(0, buf_count - 1));
                    end else begin
                        it.read_index = 12'($urandom);
                    end
                    send_item(it, 1'b0, '0);
                    items_issued++;
                    idle_tx(pick_gap(tx_burst));
                end
            end
            phase_no++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_scaled_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("audio_peak_normalizer_unit test passed");
        end else begin
            $display("audio_peak_normalizer_unit test failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/apn_pkg.sv
design/apn_store.sv
design/apn_div.sv
design/audio_peak_normalizer_unit.sv
design/apn_checker.sv
dv/audio_peak_normalizer_unit_tb.sv
